// ===== hdl/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, codes and constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [31:0] word_t;

    localparam int NUM_WORDS   = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = 7;

    localparam logic [1:0] REQ_ABSORB  = 2'd0;
    localparam logic [1:0] REQ_DIGEST  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam word_t SHA_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_FINAL,
        PAD_SPILL,
        PAD_LEN
    } pad_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_FOLD
    } ctrl_state_t;

    typedef struct packed {
        logic                 absorb_en;
        logic                 restart_en;
        logic                 snap_capture;
        logic                 init_en;
        logic                 round_en;
        logic                 fold_en;
        logic                 sel_snap;
        pad_mode_t            pad_mode;
        logic [ROUND_W-1:0]   round_t;
        logic                 emit_start;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] bytes_in_block;
        logic       overflow;
        logic       emit_busy;
    } dp_status_t;

endpackage

// ===== hdl/sha1_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_ctrl
// Request decode and compression sequencer: init, 80 rounds, fold, and the
// one- or two-block padded pass of a digest.
// ----------------------------------------------------------------------------
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t        state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    pad_mode_t          pad_mode_reg, pad_mode_next;
    logic               sel_snap_reg, sel_snap_next;
    logic               fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            pad_mode_reg <= PAD_NONE;
            sel_snap_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            pad_mode_reg <= pad_mode_next;
            sel_snap_reg <= sel_snap_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE) &&
                      ((req_type != REQ_DIGEST) || !status.emit_busy);
    assign fire = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        pad_mode_next = pad_mode_reg;
        sel_snap_next = sel_snap_reg;
        cmd           = '0;
        cmd.pad_mode  = pad_mode_reg;
        cmd.sel_snap  = sel_snap_reg;
        cmd.round_t   = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    case (req_type)
                        REQ_ABSORB:
                        begin
                            if (!status.overflow)
                            begin
                                cmd.absorb_en = 1'b1;
                                if (status.bytes_in_block == LAST_BYTE)
                                begin
                                    pad_mode_next = PAD_NONE;
                                    sel_snap_next = 1'b0;
                                    state_next    = ST_INIT;
                                end
                            end
                        end
                        REQ_DIGEST:
                        begin
                            cmd.snap_capture = 1'b1;
                            sel_snap_next    = 1'b1;
                            pad_mode_next    = (status.bytes_in_block >= LEN_START) ?
                                               PAD_SPILL : PAD_FINAL;
                            state_next       = ST_INIT;
                        end
                        REQ_RESTART:
                        begin
                            cmd.restart_en = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                cmd.init_en = 1'b1;
                round_next  = '0;
                state_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_FOLD;
                end
                else
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                if (pad_mode_reg == PAD_SPILL)
                begin
                    pad_mode_next = PAD_LEN;
                    state_next    = ST_INIT;
                end
                else
                begin
                    cmd.emit_start = sel_snap_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == ROUND_W'(ROUNDS - 1)) |=>
        (state_reg == ST_FOLD))
        else $error("round count did not end in fold");

    a_init_to_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |=> (state_reg == ST_ROUND && round_reg == '0))
        else $error("init did not start round zero");

endmodule

// ===== hdl/sha1_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer, length counter, padding, 16-word schedule window, round
// registers, chaining values and the digest word emitter.
// ----------------------------------------------------------------------------
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        overflow_error
);

    word_t       block_buf_reg [BLOCK_WORDS];
    word_t       window_reg [BLOCK_WORDS];
    word_t       rr_reg [NUM_WORDS];
    word_t       chain_reg [NUM_WORDS];
    word_t       snap_reg [NUM_WORDS];
    logic [5:0]  bytes_reg;
    logic [63:0] bit_count_reg;
    logic [63:0] bit_count_next;
    logic        overflow_reg;
    logic        emit_busy_reg;
    logic [2:0]  emit_cnt_reg;
    logic        emit_ovf_reg;

    word_t       rd_word;
    word_t       pad_word;
    word_t       sched_new;
    word_t       w_cur;
    word_t       f_val;
    word_t       k_val;
    word_t       tmp;
    logic [5:0]  j;
    logic [7:0]  raw_byte;
    logic [7:0]  len_byte;
    logic [7:0]  pad_v;
    logic [4:0]  lane_off;
    logic        out_fire;

    assign bit_count_next = bit_count_reg + 64'd8;
    assign lane_off       = {~bytes_reg[1:0], 3'b000};
    assign rd_word        = block_buf_reg[cmd.round_t[3:0]];

    always_comb
    begin
        pad_word = '0;
        j        = '0;
        raw_byte = '0;
        len_byte = '0;
        pad_v    = '0;
        for (int b = 0; b < 4; b++)
        begin
            j        = {cmd.round_t[3:0], 2'(b)};
            raw_byte = rd_word[8*(3-b) +: 8];
            len_byte = bit_count_reg[{~j[2:0], 3'b000} +: 8];
            case (cmd.pad_mode)
                PAD_NONE:
                begin
                    pad_v = raw_byte;
                end
                PAD_FINAL, PAD_SPILL:
                begin
                    if (j < bytes_reg)
                    begin
                        pad_v = raw_byte;
                    end
                    else if (j == bytes_reg)
                    begin
                        pad_v = PAD_BYTE;
                    end
                    else if (cmd.pad_mode == PAD_FINAL && j >= LEN_START)
                    begin
                        pad_v = len_byte;
                    end
                    else
                    begin
                        pad_v = '0;
                    end
                end
                PAD_LEN:
                begin
                    pad_v = (j >= LEN_START) ? len_byte : 8'h00;
                end
                default:
                begin
                    pad_v = '0;
                end
            endcase
            pad_word[8*(3-b) +: 8] = pad_v;
        end
    end

    always_comb
    begin
        sched_new = window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0];
        sched_new = {sched_new[30:0], sched_new[31]};
        w_cur     = (cmd.round_t < ROUND_W'(BLOCK_WORDS)) ? pad_word : sched_new;
        if (cmd.round_t < ROUND_W'(20))
        begin
            f_val = (rr_reg[1] & rr_reg[2]) | (~rr_reg[1] & rr_reg[3]);
            k_val = K0;
        end
        else if (cmd.round_t < ROUND_W'(40))
        begin
            f_val = rr_reg[1] ^ rr_reg[2] ^ rr_reg[3];
            k_val = K1;
        end
        else if (cmd.round_t < ROUND_W'(60))
        begin
            f_val = (rr_reg[1] & rr_reg[2]) | (rr_reg[1] & rr_reg[3]) |
                    (rr_reg[2] & rr_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = rr_reg[1] ^ rr_reg[2] ^ rr_reg[3];
            k_val = K3;
        end
        tmp = {rr_reg[0][26:0], rr_reg[0][31:27]} + f_val + rr_reg[4] + w_cur + k_val;
    end

    // block buffer and working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.absorb_en)
        begin
            block_buf_reg[bytes_reg[5:2]][lane_off +: 8] <= data_byte;
        end
        if (cmd.snap_capture)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                snap_reg[i] <= chain_reg[i];
            end
        end
        if (cmd.fold_en && cmd.sel_snap)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                snap_reg[i] <= snap_reg[i] + rr_reg[i];
            end
        end
        if (cmd.init_en)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                rr_reg[i] <= cmd.sel_snap ? snap_reg[i] : chain_reg[i];
            end
        end
        if (cmd.round_en)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[BLOCK_WORDS-1] <= w_cur;
            rr_reg[4] <= rr_reg[3];
            rr_reg[3] <= rr_reg[2];
            rr_reg[2] <= {rr_reg[1][1:0], rr_reg[1][31:2]};
            rr_reg[1] <= rr_reg[0];
            rr_reg[0] <= tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                chain_reg[i] <= SHA_INIT[i];
            end
            bytes_reg     <= '0;
            bit_count_reg <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.restart_en)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_reg[i] <= SHA_INIT[i];
                end
                bytes_reg     <= '0;
                bit_count_reg <= '0;
                overflow_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.absorb_en)
                begin
                    bytes_reg     <= bytes_reg + 1'b1;
                    bit_count_reg <= bit_count_next;
                    if (bit_count_next == '0)
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
                if (cmd.fold_en && !cmd.sel_snap)
                begin
                    for (int i = 0; i < NUM_WORDS; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + rr_reg[i];
                    end
                end
            end
        end
    end

    // digest word emitter
    assign out_fire = emit_busy_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_busy_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            emit_ovf_reg  <= 1'b0;
        end
        else if (cmd.emit_start)
        begin
            emit_busy_reg <= 1'b1;
            emit_cnt_reg  <= '0;
            emit_ovf_reg  <= overflow_reg;
        end
        else if (out_fire)
        begin
            if (emit_cnt_reg == 3'(NUM_WORDS - 1))
            begin
                emit_busy_reg <= 1'b0;
            end
            else
            begin
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        case (emit_cnt_reg)
            3'd0:    digest_word = snap_reg[0];
            3'd1:    digest_word = snap_reg[1];
            3'd2:    digest_word = snap_reg[2];
            3'd3:    digest_word = snap_reg[3];
            default: digest_word = snap_reg[4];
        endcase
    end

    assign out_valid      = emit_busy_reg;
    assign word_index     = emit_cnt_reg;
    assign last_word      = (emit_cnt_reg == 3'(NUM_WORDS - 1));
    assign overflow_error = emit_ovf_reg;

    assign status.bytes_in_block = bytes_reg;
    assign status.overflow       = overflow_reg;
    assign status.emit_busy      = emit_busy_reg;

    a_emit_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |-> !emit_busy_reg)
        else $error("digest emit started while previous digest still pending");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> !emit_busy_reg)
        else $error("emitter busy after final digest word");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart_en |=> (bit_count_reg == '0 && !overflow_reg && bytes_reg == '0))
        else $error("restart did not clear length state");

endmodule

// ===== hdl/sha1_hash_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 engine taking one byte or command per beat and giving five digest
// words per digest request.
// ----------------------------------------------------------------------------
// absorb: one byte per beat while idle; the byte closing a block starts init,
//   80 rounds at one round per cycle and fold, with in_ready low until the fold
// digest: one padded block or two, then five digest words;
//   absorb and restart are taken while the words drain
// reset: chaining value set to the initial value, counters and flag cleared
// ----------------------------------------------------------------------------
module sha1_hash_engine
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        overflow_error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha1_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    sha1_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .overflow_error (overflow_error)
    );

endmodule
